// ===== rtl/core/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg: shared definitions for the UTF-8 byte decoder
// Byte classes, status codes and the transition table of the decoding DFA.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned CLASS_W  = 4;
    localparam int unsigned POINT_W  = 21;
    localparam int unsigned NUM_STATES = 9;
    localparam int unsigned NUM_CLASSES = 16;
    localparam int unsigned PAYLOAD_BITS = 6;

    localparam logic [STATE_W-1:0] ACCEPT_STATE = 4'd0;
    localparam logic [STATE_W-1:0] REJECT_STATE = 4'd1;
    localparam logic [POINT_W-1:0] MAX_SCALAR   = 21'h10FFFF;

    typedef enum logic [1:0] {
        STATUS_COMPLETE = 2'd0,
        STATUS_MORE     = 2'd1,
        STATUS_REJECT   = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [POINT_W-1:0]   code_point;
    } result_t;

    typedef logic [STATE_W-1:0] row_t [NUM_CLASSES];

    // Next state, indexed [state][class].
    localparam row_t NEXT_TAB [NUM_STATES] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    // Maps a raw byte to its character class.
    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] cls;
        priority if (b < 8'h80)  cls = 4'd0;
        else if (b < 8'h90)      cls = 4'd1;
        else if (b < 8'hA0)      cls = 4'd9;
        else if (b < 8'hC0)      cls = 4'd7;
        else if (b < 8'hC2)      cls = 4'd8;
        else if (b < 8'hE0)      cls = 4'd2;
        else if (b == 8'hE0)     cls = 4'd10;
        else if (b == 8'hED)     cls = 4'd4;
        else if (b < 8'hF0)      cls = 4'd3;
        else if (b == 8'hF0)     cls = 4'd11;
        else if (b < 8'hF4)      cls = 4'd6;
        else if (b == 8'hF4)     cls = 4'd5;
        else                     cls = 4'd8;
        return cls;
    endfunction

    // Transition lookup; a state outside the table behaves as reject.
    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                      input logic [CLASS_W-1:0] cls);
        logic [STATE_W-1:0] nxt;
        if (st >= STATE_W'(NUM_STATES)) begin
            nxt = REJECT_STATE;
        end else begin
            nxt = NEXT_TAB[st][cls];
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/u8d_dfa.sv =====
// ----------------------------------------------------------------------------
// u8d_dfa: decoding state machine and code point accumulator
// Holds the DFA state and the partial code point, and forms one result per
// accepted byte.
// ----------------------------------------------------------------------------
module u8d_dfa (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [u8d_pkg::BYTE_W-1:0]     in_byte,
    output u8d_pkg::result_t               result
);

    logic [u8d_pkg::STATE_W-1:0] dfa_state_reg, dfa_state_next;
    logic [u8d_pkg::POINT_W-1:0] point_accum_reg, point_accum_next;
    logic [u8d_pkg::CLASS_W-1:0] cls;
    logic [u8d_pkg::BYTE_W-1:0]  lead_mask;

    always_comb begin
        cls            = u8d_pkg::byte_class(in_byte);
        lead_mask      = 8'hFF >> cls;
        dfa_state_next = u8d_pkg::next_state(dfa_state_reg, cls);
        if (dfa_state_reg != u8d_pkg::ACCEPT_STATE) begin
            point_accum_next = {point_accum_reg[u8d_pkg::POINT_W-u8d_pkg::PAYLOAD_BITS-1:0],
                                in_byte[u8d_pkg::PAYLOAD_BITS-1:0]};
        end else begin
            point_accum_next = u8d_pkg::POINT_W'(lead_mask & in_byte);
        end

        if (dfa_state_next == u8d_pkg::ACCEPT_STATE) begin
            result.status     = u8d_pkg::STATUS_COMPLETE;
            result.code_point = point_accum_next;
        end else if (dfa_state_next == u8d_pkg::REJECT_STATE) begin
            result.status     = u8d_pkg::STATUS_REJECT;
            result.code_point = '0;
        end else begin
            result.status     = u8d_pkg::STATUS_MORE;
            result.code_point = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfa_state_reg   <= u8d_pkg::ACCEPT_STATE;
            point_accum_reg <= '0;
        end else if (step) begin
            dfa_state_reg   <= dfa_state_next;
            point_accum_reg <= point_accum_next;
        end
    end

    a_reject_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        dfa_state_reg == u8d_pkg::REJECT_STATE |=> dfa_state_reg == u8d_pkg::REJECT_STATE)
        else $error("reject state was left without reset");

    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dfa_state_reg < u8d_pkg::STATE_W'(u8d_pkg::NUM_STATES))
        else $error("DFA state outside the table");

    a_scalar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.status == u8d_pkg::STATUS_COMPLETE |->
            result.code_point <= u8d_pkg::MAX_SCALAR)
        else $error("completed code point above the Unicode range");

endmodule

// ===== rtl/core/u8d_obuf.sv =====
// ----------------------------------------------------------------------------
// u8d_obuf: two-entry result buffer
// An output register plus a skid register, so the input side sees a
// registered ready and keeps taking items while a result waits.
// ----------------------------------------------------------------------------
module u8d_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8d_pkg::result_t  push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output u8d_pkg::result_t  out_data
);

    logic             out_valid_reg, skid_valid_reg;
    u8d_pkg::result_t out_data_reg, skid_data_reg;
    logic             pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

endmodule

// ===== rtl/core/utf8_byte_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_decoder_core: validating UTF-8 byte decoder
// Takes one byte per item and returns one status and code point per byte.
// ----------------------------------------------------------------------------
// The decoder accepts one byte per clock while s_ready is high and returns
// exactly one result item for every byte, in order. Each byte is classified,
// the DFA state advances through a small transition table, and the code
// point is built from the lead byte and the six payload bits of each
// continuation byte; all of this is one short combinational step between the
// state registers and the result buffer, so throughput is one item per cycle
// while s_ready stays high, and each result is registered in that buffer.
// A two-entry result buffer keeps s_ready registered and lets the input keep
// flowing while a result waits. Status 0 means a code point is complete and
// m_code_point holds it, status 1 means a sequence is in progress, and status
// 2 means the stream was rejected; rejection is sticky until aresetn is
// asserted, and the code point reads zero for any status other than complete.
// ----------------------------------------------------------------------------
module utf8_byte_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]     s_in_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [u8d_pkg::POINT_W-1:0]    m_code_point
);

    logic             accept;
    u8d_pkg::result_t step_result;
    u8d_pkg::result_t out_result;

    // An item is taken whenever the skid register is free.
    assign accept = s_valid && s_ready;

    // Decoding step: state and accumulator advance on every accepted item.
    u8d_dfa u_dfa (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .in_byte (s_in_byte),
        .result  (step_result)
    );

    // Result buffer parts the input and output handshakes.
    u8d_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_result),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_status     = out_result.status;
    assign m_code_point = out_result.code_point;

    a_point_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != u8d_pkg::STATUS_COMPLETE |-> m_code_point == '0)
        else $error("code point shown with a status other than complete");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code on output");

endmodule

// ===== test/tb_utf8_byte_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_decoder_core: self-checking regression for the UTF-8 decoder
// Streams well-formed UTF-8 with random content and random flow control
// through the decoder. Every status and code point is checked against a
// local model of the decoding DFA. The run ends with a malformed stream,
// because rejection is sticky until reset.
// ----------------------------------------------------------------------------
module tb_utf8_byte_decoder_core;

    // Longest quiet stretch that a correct run can show is the forced output
    // hold-off; the watchdog limit sits well above it.
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // Character classes of the decoding DFA.
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_ASCII    = 4'd0;  // 00..7F
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_CONT_LO  = 4'd1;  // 80..8F
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD2    = 4'd2;  // C2..DF
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD3    = 4'd3;  // E1..EC, EE..EF
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD_ED  = 4'd4;  // ED
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD_F4  = 4'd5;  // F4
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD4    = 4'd6;  // F1..F3
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_CONT_HI  = 4'd7;  // A0..BF
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_INVALID  = 4'd8;  // C0, C1, F5..FF
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_CONT_MID = 4'd9;  // 90..9F
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD_E0  = 4'd10; // E0
    localparam logic [u8d_pkg::CLASS_W-1:0] CLS_LEAD_F0  = 4'd11; // F0

    // The ways a stream is broken at the end of the run.
    typedef enum int {
        BAD_LONE_CONT,
        BAD_C0_C1,
        BAD_F5_FF,
        BAD_E0_OVERLONG,
        BAD_SURROGATE,
        BAD_F0_OVERLONG,
        BAD_ABOVE_MAX,
        BAD_TRUNCATED
    } flaw_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [u8d_pkg::BYTE_W-1:0]   s_in_byte = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_status;
    logic [u8d_pkg::POINT_W-1:0]  m_code_point;

    // Local copy of the decoder state, advanced once per accepted item.
    logic [u8d_pkg::STATE_W-1:0]  dec_state;
    logic [u8d_pkg::POINT_W-1:0]  dec_accum;

    // Results that the decoder still owes, oldest first.
    u8d_pkg::result_t             pending_results[$];

    // Bytes of the scalar value that is being sent.
    logic [u8d_pkg::BYTE_W-1:0]   seq_bytes [4];
    int unsigned                  seq_len;

    int unsigned                  mismatches = 0;
    int unsigned                  bytes_accepted = 0;
    // Random idling on both channels is enabled while this is set.
    bit                           bursty = 1'b0;
    // Requests a long output hold-off; the receiver clears it when done.
    bit                           hold_out_req = 1'b0;

    utf8_byte_decoder_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_code_point (m_code_point)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    function automatic logic [u8d_pkg::CLASS_W-1:0] classify_byte(
        input logic [u8d_pkg::BYTE_W-1:0] b
    );
        logic [u8d_pkg::CLASS_W-1:0] cls;
        if (b < 8'h80) begin
            cls = CLS_ASCII;
        end else if (b < 8'h90) begin
            cls = CLS_CONT_LO;
        end else if (b < 8'hA0) begin
            cls = CLS_CONT_MID;
        end else if (b < 8'hC0) begin
            cls = CLS_CONT_HI;
        end else if (b < 8'hC2) begin
            cls = CLS_INVALID;
        end else if (b < 8'hE0) begin
            cls = CLS_LEAD2;
        end else if (b == 8'hE0) begin
            cls = CLS_LEAD_E0;
        end else if (b == 8'hED) begin
            cls = CLS_LEAD_ED;
        end else if (b < 8'hF0) begin
            cls = CLS_LEAD3;
        end else if (b == 8'hF0) begin
            cls = CLS_LEAD_F0;
        end else if (b < 8'hF4) begin
            cls = CLS_LEAD4;
        end else if (b == 8'hF4) begin
            cls = CLS_LEAD_F4;
        end else begin
            cls = CLS_INVALID;
        end
        return cls;
    endfunction

    // One row of the transition table, packed with class 0 in the low nibble.
    function automatic logic [63:0] transition_row(input logic [u8d_pkg::STATE_W-1:0] st);
        logic [63:0] row;
        case (st)
            u8d_pkg::ACCEPT_STATE: row = 64'h1111_6411_1785_3210;
            4'd2:                  row = 64'h1111_1101_0111_1101;
            4'd3:                  row = 64'h1111_1121_2111_1121;
            4'd4:                  row = 64'h1111_1111_2111_1111;
            4'd5:                  row = 64'h1111_1121_1111_1121;
            4'd6:                  row = 64'h1111_1131_3111_1111;
            4'd7:                  row = 64'h1111_1131_3111_1131;
            4'd8:                  row = 64'h1111_1111_1111_1131;
            default:               row = 64'h1111_1111_1111_1111;
        endcase
        return row;
    endfunction

    // Advances the model by one byte and returns the result it must produce.
    function automatic u8d_pkg::result_t decode_step(input logic [u8d_pkg::BYTE_W-1:0] b);
        logic [u8d_pkg::CLASS_W-1:0] cls;
        logic [u8d_pkg::STATE_W-1:0] cur;
        logic [u8d_pkg::STATE_W-1:0] nxt;
        logic [63:0]                 row;
        u8d_pkg::result_t            res;
        cls = classify_byte(b);
        cur = dec_state;
        if (cur >= u8d_pkg::STATE_W'(u8d_pkg::NUM_STATES)) begin
            cur = u8d_pkg::REJECT_STATE;
        end
        // A lead byte keeps only its payload bits; any later byte, including
        // bytes after a rejection, shifts six more bits into the accumulator.
        if (cur == u8d_pkg::ACCEPT_STATE) begin
            dec_accum = u8d_pkg::POINT_W'((8'hFF >> cls) & b);
        end else begin
            dec_accum = {dec_accum[u8d_pkg::POINT_W-7:0], b[5:0]};
        end
        row = transition_row(cur);
        nxt = row[cls*4 +: 4];
        dec_state = nxt;
        if (nxt == u8d_pkg::ACCEPT_STATE) begin
            res.status     = u8d_pkg::STATUS_COMPLETE;
            res.code_point = dec_accum;
        end else if (nxt == u8d_pkg::REJECT_STATE) begin
            res.status     = u8d_pkg::STATUS_REJECT;
            res.code_point = '0;
        end else begin
            res.status     = u8d_pkg::STATUS_MORE;
            res.code_point = '0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one byte and holds it until the decoder takes it. Valid is never
    // lowered here, so back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        u8d_pkg::result_t owed;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        owed            = decode_step(b);
        pending_results = {pending_results, owed};
        bytes_accepted++;
    endtask

    // Drops valid for the given number of cycles. The data lines carry junk
    // meanwhile, which the decoder must ignore.
    task automatic sender_gap(input int unsigned cycles);
        @(negedge aclk);
        s_valid   <= 1'b0;
        s_in_byte <= u8d_pkg::BYTE_W'($urandom);
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Waits with valid low until every owed result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic encode_scalar(input logic [u8d_pkg::POINT_W-1:0] cp);
        if (cp < 21'h80) begin
            seq_len      = 1;
            seq_bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            seq_len      = 2;
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            seq_len      = 3;
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {2'b10, cp[11:6]};
            seq_bytes[2] = {2'b10, cp[5:0]};
        end else begin
            seq_len      = 4;
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {2'b10, cp[17:12]};
            seq_bytes[2] = {2'b10, cp[11:6]};
            seq_bytes[3] = {2'b10, cp[5:0]};
        end
    endtask

    // Sends one scalar value as UTF-8; with idling on, gaps may fall before
    // any byte, so they land in every state a well-formed sequence passes through.
    task automatic send_scalar(input logic [u8d_pkg::POINT_W-1:0] cp);
        encode_scalar(cp);
        for (int i = 0; i < seq_len; i++) begin
            if (bursty && $urandom_range(0, 5) == 0) begin
                sender_gap($urandom_range(1, 18));
            end
            send_byte(seq_bytes[i]);
        end
    endtask

    // Random scalar value, spread over the four encoded lengths with the
    // range edges drawn often and surrogate-gap picks moved to the gap's edges.
    function automatic logic [u8d_pkg::POINT_W-1:0] random_scalar();
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        logic [u8d_pkg::POINT_W-1:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            lo = 'h0;
            hi = 'h7F;
        end else if (pick < 55) begin
            lo = 'h80;
            hi = 'h7FF;
        end else if (pick < 80) begin
            lo = 'h800;
            hi = 'hFFFF;
        end else begin
            lo = 'h10000;
            hi = 'h10FFFF;
        end
        case ($urandom_range(0, 9))
            0:       cp = u8d_pkg::POINT_W'(lo);
            1:       cp = u8d_pkg::POINT_W'(hi);
            default: cp = u8d_pkg::POINT_W'($urandom_range(hi, lo));
        endcase
        if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
            cp = $urandom_range(0, 1) ? 21'hD7FF : 21'hE000;
        end
        return cp;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The smallest and largest value of every encoded length, plus the value
    // right below the surrogate gap, so that the E0, ED, F0 and F4 leads with
    // their narrowed continuation ranges are all taken.
    task automatic test_valid_extremes();
        send_scalar(21'h00);
        send_scalar(21'h7F);
        send_scalar(21'h80);
        send_scalar(21'h7FF);
        send_scalar(21'h800);
        send_scalar(21'hD7FF);
        send_scalar(21'hFFFF);
        send_scalar(21'h10000);
        send_scalar(u8d_pkg::MAX_SCALAR);
    endtask

    // Well-formed text with random content. Idling is switched per stretch so
    // that some stretches run at full rate.
    task automatic test_random_streams(input int unsigned count);
        int unsigned stop_at;
        int unsigned next_switch;
        stop_at     = bytes_accepted + count;
        next_switch = bytes_accepted;
        while (bytes_accepted < stop_at) begin
            if (bytes_accepted >= next_switch) begin
                bursty      = ($urandom_range(0, 3) != 0);
                next_switch = bytes_accepted + $urandom_range(60, 200);
            end
            send_scalar(random_scalar());
        end
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so
    // the result buffer fills and the decoder must stall its input.
    task automatic test_output_backpressure();
        bursty       = 1'b0;
        hold_out_req = 1'b1;
        for (int i = 0; i < 50; i++) begin
            send_scalar(random_scalar());
        end
        while (hold_out_req) @(posedge aclk);
    endtask

    // The sender stops after a random byte of a sequence and waits until every
    // result has drained before it resumes; any partial state must survive the pause.
    task automatic test_drain_mid_sequence();
        int unsigned cut;
        bursty = 1'b0;
        for (int n = 0; n < 8; n++) begin
            encode_scalar(random_scalar());
            cut = $urandom_range(0, seq_len - 1);
            for (int i = 0; i < seq_len; i++) begin
                send_byte(seq_bytes[i]);
                if (i == cut) begin
                    drain_results();
                end
            end
        end
    endtask

    // Breaks the stream in one of the ways the DFA must catch, then shows
    // that rejection is absorbing: later bytes, valid or not, are rejected.
    // This runs last since only reset leaves the reject state.
    task automatic test_reject_sticky();
        flaw_t flaw;
        bursty = 1'b0;
        flaw   = flaw_t'($urandom_range(0, 7));
        case (flaw)
            BAD_LONE_CONT: begin
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
            BAD_C0_C1: begin
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hC1, 8'hC0)));
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
            BAD_F5_FF: begin
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hFF, 8'hF5)));
            end
            BAD_E0_OVERLONG: begin
                send_byte(8'hE0);
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'h9F, 8'h80)));
            end
            BAD_SURROGATE: begin
                send_byte(8'hED);
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hBF, 8'hA0)));
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
            BAD_F0_OVERLONG: begin
                send_byte(8'hF0);
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'h8F, 8'h80)));
            end
            BAD_ABOVE_MAX: begin
                send_byte(8'hF4);
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hBF, 8'h90)));
            end
            default: begin
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'hDF, 8'hC2)));
                send_byte(u8d_pkg::BYTE_W'($urandom_range(8'h7F, 8'h00)));
            end
        endcase
        send_byte(8'hFF);
        send_byte(8'h00);
        for (int i = 0; i < 300; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_scalar(random_scalar());
            end else begin
                send_byte(u8d_pkg::BYTE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Drives m_ready: random stall bursts while idling is on, and a single
    // long hold-off on request.
    always begin : result_receiver
        @(negedge aclk);
        if (hold_out_req) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge aclk);
            hold_out_req = 1'b0;
        end else if (bursty && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result is matched against the oldest owed result.
    always @(posedge aclk) begin : result_check
        u8d_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none owed: status %0d, code point %h",
                         $time, m_status, m_code_point);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, m_status);
                    mismatches++;
                end
                if (m_code_point !== want.code_point) begin
                    $display("%0t: code point expected %h, actual %h",
                             $time, want.code_point, m_code_point);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("utf8_byte_decoder_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin : test_sequence
        dec_state = u8d_pkg::ACCEPT_STATE;
        dec_accum = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_valid_extremes();
        test_random_streams(700);
        test_output_backpressure();
        test_drain_mid_sequence();
        test_random_streams(700);
        test_reject_sticky();

        // Let the last results come back, then a few spare cycles so that a
        // stray extra result would still be caught.
        drain_results();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("utf8_byte_decoder_core regression: pass");
        end else begin
            $display("utf8_byte_decoder_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_dfa.sv
rtl/core/u8d_obuf.sv
rtl/core/utf8_byte_decoder_core.sv
test/tb_utf8_byte_decoder_core.sv
